>>> hw/rtl/pps_pkg.sv
// shared types, constants and helpers of the priority scheduler
package pps_pkg;

	localparam int QDEPTH    = 16;
	localparam int LEVELS    = 3;
	localparam int PID_W     = 8;
	localparam int LVL_W     = 2;
	localparam int IDX_W     = $clog2(QDEPTH);
	localparam int CNT_W     = $clog2(QDEPTH + 1);
	localparam int MEM_DEPTH = LEVELS * QDEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	// operation codes as they arrive on the input stream
	typedef enum logic [1:0] {
		OP_READY   = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	// status codes of a result
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_IDLE    = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	// classified item passed from the front end to the engine
	typedef struct packed {
		op_t              op;
		logic [PID_W-1:0] pid;
		logic [LVL_W-1:0] lvl;
	} item_t;

	// result of one item
	typedef struct packed {
		status_t          status;
		logic             switched;
		logic [LVL_W-1:0] running_priority;
		logic [PID_W-1:0] running_pid;
		logic             running_valid;
	} res_t;

	// tail slot of a ring given its head and occupancy
	function automatic logic [IDX_W-1:0] tail_idx(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] count);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
		if (sum >= (CNT_W+1)'(QDEPTH))
			sum = sum - (CNT_W+1)'(QDEPTH);
		return sum[IDX_W-1:0];
	endfunction

	// slot after the given one, wrapping at the ring end
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		if (idx == IDX_W'(QDEPTH - 1))
			return '0;
		return idx + IDX_W'(1);
	endfunction

	// flat memory address of a slot of a level
	function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(lvl) * ADDR_W'(QDEPTH) + ADDR_W'(idx);
	endfunction

endpackage

>>> hw/rtl/pps_front.sv
// front end: takes input transfers, decodes the operation and clamps the level
module pps_front import pps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // [7:0] pid, [9:8] priority_req, rest zero
	input  logic [1:0]           s_tuser,   // [1:0] operation
	output logic                 item_valid,
	input  logic                 item_ready,
	output item_t                item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic [LVL_W-1:0] lvl_in;

	// decode and clamp the level to the top one
	always_comb begin
		lvl_in = s_tdata[PID_W +: LVL_W];
		item_d.op  = op_t'(s_tuser);
		item_d.pid = s_tdata[PID_W-1:0];
		if (32'(lvl_in) >= LEVELS)
			item_d.lvl = LVL_W'(LEVELS - 1);
		else
			item_d.lvl = lvl_in;
	end

	assign s_tready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// holding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> hw/rtl/pps_fifo.sv
// two-entry queue between front end and engine
module pps_fifo import pps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_item
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> hw/rtl/pps_engine.sv
// back end: ready queues in memory, running process and dispatch decision
module pps_engine import pps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	typedef enum logic [1:0] {
		S_EXEC = 2'b01,
		S_POP  = 2'b10
	} state_t;

	state_t state_q;

	// ready queue storage, one ring of QDEPTH slots per level
	logic [PID_W-1:0] mem [MEM_DEPTH];
	logic [PID_W-1:0] rd_data_q;

	logic [IDX_W-1:0] heads_q  [LEVELS];
	logic [CNT_W-1:0] counts_q [LEVELS];
	logic [PID_W-1:0] cur_pid_q;
	logic [LVL_W-1:0] cur_lvl_q;
	logic             cur_valid_q;

	// per item bookkeeping between the two steps
	logic             dispatch_q;
	logic             preempt_q;
	logic             dropped_q;
	logic [LVL_W-1:0] top_q;
	logic             start_valid_q;
	logic [PID_W-1:0] start_pid_q;
	logic             bypass_q;
	logic [PID_W-1:0] bypass_pid_q;

	logic  out_valid_q;
	res_t  out_q;

	// execute step signals
	logic             exec_fire;
	logic             push_req;
	logic [LVL_W-1:0] push_lvl;
	logic [PID_W-1:0] push_pid;
	logic             push_ok;
	logic             push_drop;
	logic [ADDR_W-1:0] push_addr;
	logic [CNT_W-1:0] counts_post [LEVELS];
	logic             valid_post;
	logic [LVL_W-1:0] top;
	logic             found;
	logic             dispatch;
	logic [ADDR_W-1:0] rd_addr;

	// pop step signals
	logic             out_free;
	logic             pop_fire;
	logic             pre_full;
	logic [ADDR_W-1:0] pre_addr;
	logic [PID_W-1:0] next_pid;
	logic             fin_valid;
	logic [PID_W-1:0] fin_pid;
	logic [LVL_W-1:0] fin_lvl;
	logic             fin_dropped;

	// memory write port
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [PID_W-1:0]  wr_data;

	assign item_ready = (state_q == S_EXEC);
	assign exec_fire  = item_valid && item_ready;
	assign out_free   = !out_valid_q || res_ready;
	assign pop_fire   = (state_q == S_POP) && out_free;

	// operation, then post-op occupancy and highest non-empty level
	always_comb begin
		push_req = 1'b0;
		push_lvl = item.lvl;
		push_pid = item.pid;
		valid_post = cur_valid_q;
		case (item.op)
			OP_READY: begin
				push_req = 1'b1;
			end
			OP_TIMEOUT: begin
				push_req   = cur_valid_q;
				push_lvl   = cur_lvl_q;
				push_pid   = cur_pid_q;
				valid_post = 1'b0;
			end
			OP_RELEASE: begin
				valid_post = 1'b0;
			end
			default: begin
			end
		endcase
		push_drop = push_req && (counts_q[push_lvl] == CNT_W'(QDEPTH));
		push_ok   = push_req && !push_drop;
		push_addr = mem_addr(push_lvl, tail_idx(heads_q[push_lvl], counts_q[push_lvl]));
		found = 1'b0;
		top   = '0;
		for (int l = 0; l < LEVELS; l++) begin
			counts_post[l] = counts_q[l];
			if (push_ok && push_lvl == LVL_W'(l))
				counts_post[l] = counts_q[l] + CNT_W'(1);
			if (counts_post[l] != '0) begin
				found = 1'b1;
				top   = LVL_W'(l);
			end
		end
		dispatch = found && (!valid_post || top > cur_lvl_q);
		rd_addr  = mem_addr(top, heads_q[top]);
	end

	// preempted process goes back to the tail of its own level
	always_comb begin
		pre_full = (counts_q[cur_lvl_q] == CNT_W'(QDEPTH));
		pre_addr = mem_addr(cur_lvl_q, tail_idx(heads_q[cur_lvl_q], counts_q[cur_lvl_q]));
		next_pid = bypass_q ? bypass_pid_q : rd_data_q;
		fin_dropped = dropped_q || (preempt_q && pre_full);
		if (dispatch_q) begin
			fin_valid = 1'b1;
			fin_pid   = next_pid;
			fin_lvl   = top_q;
		end else begin
			fin_valid = cur_valid_q;
			fin_pid   = cur_pid_q;
			fin_lvl   = cur_lvl_q;
		end
	end

	// one write per step: the operation's push, or the preempted process
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = push_addr;
		wr_data = push_pid;
		if (exec_fire && push_ok) begin
			wr_en = 1'b1;
		end else if (pop_fire && preempt_q && !pre_full) begin
			wr_en   = 1'b1;
			wr_addr = pre_addr;
			wr_data = cur_pid_q;
		end
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (exec_fire)
			rd_data_q <= mem[rd_addr];
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_EXEC;
			cur_pid_q   <= '0;
			cur_lvl_q   <= '0;
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			dispatch_q  <= 1'b0;
			preempt_q   <= 1'b0;
			dropped_q   <= 1'b0;
			top_q       <= '0;
			bypass_q    <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				heads_q[l]  <= '0;
				counts_q[l] <= '0;
			end
		end else begin
			// result register: filled by the pop step, emptied by a result transfer
			if (pop_fire)
				out_valid_q <= 1'b1;
			else if (res_valid && res_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_EXEC: begin
					if (exec_fire) begin
						state_q    <= S_POP;
						dispatch_q <= dispatch;
						preempt_q  <= dispatch && valid_post;
						dropped_q  <= push_drop;
						top_q      <= top;
						bypass_q   <= push_ok && (push_addr == rd_addr);
						if (!valid_post) begin
							cur_valid_q <= 1'b0;
							cur_pid_q   <= '0;
							cur_lvl_q   <= '0;
						end
						for (int l = 0; l < LEVELS; l++) begin
							if (dispatch && top == LVL_W'(l)) begin
								counts_q[l] <= counts_post[l] - CNT_W'(1);
								heads_q[l]  <= next_idx(heads_q[l]);
							end else begin
								counts_q[l] <= counts_post[l];
							end
						end
					end
				end
				S_POP: begin
					if (pop_fire) begin
						state_q     <= S_EXEC;
						cur_valid_q <= fin_valid;
						cur_pid_q   <= fin_pid;
						cur_lvl_q   <= fin_lvl;
						if (preempt_q && !pre_full)
							counts_q[cur_lvl_q] <= counts_q[cur_lvl_q] + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_EXEC;
				end
			endcase
		end
	end

	// item payload held for the pop step, and the result register
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			start_valid_q <= cur_valid_q;
			start_pid_q   <= cur_pid_q;
			bypass_pid_q  <= push_pid;
		end
		if (pop_fire) begin
			out_q.running_valid    <= fin_valid;
			out_q.running_pid      <= fin_valid ? fin_pid : '0;
			out_q.running_priority <= fin_valid ? fin_lvl : '0;
			out_q.switched <= dispatch_q && (!start_valid_q || start_pid_q != next_pid);
			if (fin_dropped)
				out_q.status <= ST_DROPPED;
			else if (!fin_valid)
				out_q.status <= ST_IDLE;
			else
				out_q.status <= ST_OK;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

>>> hw/rtl/priority_preemptive_scheduler_core.sv
// top level of the three-level preemptive round-robin scheduler
//
// Each input transfer carries one scheduling event (make ready, time-out of the
// running process, release of the running process) and yields exactly one result
// transfer with the running process after the event, a switch flag and a status.
// The engine handles each event in an execute step and a pop step, split by its
// registered queue memory read: the execute step applies the event and reads the
// head of the highest non-empty level, the pop step takes the registered read and
// writes back a preempted process. A two-entry queue and an input stage let up to
// three events wait while a result is held, and a held result does not stop the
// next event from being taken in. There is no clearing pass after reset; the input
// is ready to accept the first event as soon as reset is released.
module priority_preemptive_scheduler_core import pps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] pid, [9:8] priority_req, [15:10] zero
	input  logic [1:0]            s_tuser,   // [1:0] operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [0] running_valid, [8:1] running_pid,
	                                         // [10:9] running_priority, [11] switched,
	                                         // [13:12] status, [15:14] zero
);

	logic  fr_valid;
	logic  fr_ready;
	item_t fr_item;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;
	res_t  res;

	// decode stage
	pps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	// decoupling queue
	pps_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_item  (fr_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	// scheduling engine
	pps_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// result packing
	assign m_tdata = OUT_DATA_W'({res.status, res.switched, res.running_priority,
		res.running_pid, res.running_valid});

endmodule

>>> test/tb_priority_preemptive_scheduler_core.sv
// self-checking testbench of the three-level preemptive round-robin scheduler
module tb_priority_preemptive_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pps_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_EVENTS = 440;
	localparam int SETTLE       = 16;

	// one row of the directed plan; reps > 1 sends consecutive pids
	typedef struct {
		op_t              op;
		logic [PID_W-1:0] pid;
		logic [LVL_W-1:0] lvl;
		int               reps;
		bit               typed;
		res_t             want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] pid, [9:8] priority_req, [15:10] zero
	logic [1:0]            s_tuser = '0;   // [1:0] operation
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [0] running_valid, [8:1] running_pid,
	                                       // [10:9] running_priority, [11] switched,
	                                       // [13:12] status, [15:14] zero

	// scheduler mirror: ready queues and the running process
	logic [PID_W-1:0] ready_q [LEVELS][$];
	logic [PID_W-1:0] run_pid = '0;
	logic [LVL_W-1:0] run_lvl = '0;
	bit               run_valid = 1'b0;

	res_t pending_results[$];
	res_t got_res, want_res;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   errors = 0;
	int   cycles = 0;
	int   n_events = 0;
	int   n_checked = 0;
	int   n_switch = 0;
	int   n_drop = 0;
	int   n_idle = 0;

	priority_preemptive_scheduler_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, pending_results.size());
			$display("tb_priority_preemptive_scheduler_core NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
		errors++;
	endtask

	function automatic res_t make_outcome(input bit v, input logic [PID_W-1:0] pid,
			input logic [LVL_W-1:0] pri, input bit sw, input status_t st);
		res_t r;
		r.running_valid    = v;
		r.running_pid      = pid;
		r.running_priority = pri;
		r.switched         = sw;
		r.status           = st;
		return r;
	endfunction

	// tail append, refused when the level is full
	function automatic bit enqueue(input int lvl, input logic [PID_W-1:0] pid);
		if (ready_q[lvl].size() >= QDEPTH)
			return 1'b0;
		ready_q[lvl].push_back(pid);
		return 1'b1;
	endfunction

	// apply one event to the mirror, reschedule and return the result
	function automatic res_t apply_event(input op_t op, input logic [PID_W-1:0] pid,
			input logic [LVL_W-1:0] lvl_req);
		int               lvl;
		int               top;
		bit               found;
		bit               start_valid;
		logic [PID_W-1:0] start_pid;
		logic [PID_W-1:0] nxt;
		bit               dropped;
		bit               dispatched;
		res_t             r;
		lvl         = (int'(lvl_req) >= LEVELS) ? LEVELS - 1 : int'(lvl_req);
		start_valid = run_valid;
		start_pid   = run_pid;
		dropped     = 1'b0;
		dispatched  = 1'b0;
		found       = 1'b0;
		top         = 0;
		case (op)
			OP_READY: begin
				dropped = !enqueue(lvl, pid);
			end
			OP_TIMEOUT: begin
				if (run_valid) begin
					run_valid = 1'b0;
					dropped   = !enqueue(int'(run_lvl), run_pid);
					run_pid   = '0;
					run_lvl   = '0;
				end
			end
			OP_RELEASE: begin
				run_valid = 1'b0;
				run_pid   = '0;
				run_lvl   = '0;
			end
			default: ;
		endcase
		// highest non-empty level
		for (int i = LEVELS - 1; i >= 0 && !found; i--) begin
			if (ready_q[i].size() != 0) begin
				top   = i;
				found = 1'b1;
			end
		end
		// dispatch on an idle cpu or preempt a lower level
		if (found && (!run_valid || top > int'(run_lvl))) begin
			nxt = ready_q[top].pop_front();
			if (run_valid && !enqueue(int'(run_lvl), run_pid))
				dropped = 1'b1;
			run_pid    = nxt;
			run_lvl    = LVL_W'(top);
			run_valid  = 1'b1;
			dispatched = 1'b1;
		end
		r.running_valid    = run_valid;
		r.running_pid      = run_valid ? run_pid : '0;
		r.running_priority = run_valid ? run_lvl : '0;
		r.switched         = dispatched && (!start_valid || start_pid != run_pid);
		if (dropped)
			r.status = ST_DROPPED;
		else if (!run_valid)
			r.status = ST_IDLE;
		else
			r.status = ST_OK;
		return r;
	endfunction

	// one input transfer; called and returns at a falling edge
	task automatic send_event(input op_t op, input logic [PID_W-1:0] pid,
			input logic [LVL_W-1:0] lvl, input bit typed, input res_t want);
		res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{(IN_DATA_W - PID_W - LVL_W){1'b0}}, lvl, pid};
		s_tuser  = op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = apply_event(op, pid, lvl);
		if (typed)
			r = want;
		pending_results.push_back(r);
		n_events++;
		n_switch += r.switched;
		n_drop   += (r.status == ST_DROPPED);
		n_idle   += (r.status == ST_IDLE);
		@(negedge clk);
	endtask

	// hold off the sender until every result is back
	task automatic wait_results;
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// result receiver with random back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = res_t'(m_tdata[13:0]);
			if (m_tdata[15:14] != 2'b00)
				report_mismatch("padding bits", m_tdata[15:14], 0);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.running_valid != want_res.running_valid)
					report_mismatch("running_valid", got_res.running_valid,
						want_res.running_valid);
				if (got_res.running_pid != want_res.running_pid)
					report_mismatch("running_pid", got_res.running_pid, want_res.running_pid);
				if (got_res.running_priority != want_res.running_priority)
					report_mismatch("running_priority", got_res.running_priority,
						want_res.running_priority);
				if (got_res.switched != want_res.switched)
					report_mismatch("switched", got_res.switched, want_res.switched);
				if (got_res.status != want_res.status)
					report_mismatch("status", got_res.status, want_res.status);
				n_checked++;
			end
		end
	end

	initial begin
		row_t             plan[$];
		res_t             idle_res;
		res_t             none;
		op_t              op;
		int               ready_w;
		int               r;
		idle_res = make_outcome(1'b0, '0, '0, 1'b0, ST_IDLE);
		none     = make_outcome(1'b0, '0, '0, 1'b0, ST_OK);

		// hold reset, then release it at a falling edge
		send_idle_pct = 12;
		recv_idle_pct = 63;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed plan: idle cpu, saturated level, round robin, preemption, full queue
		plan.push_back('{OP_TIMEOUT, 8'h00, 2'd0, 1, 1'b1, idle_res});
		plan.push_back('{OP_RELEASE, 8'h00, 2'd0, 1, 1'b1, idle_res});
		plan.push_back('{OP_NOP,     8'h00, 2'd0, 1, 1'b1, idle_res});
		plan.push_back('{OP_READY,   8'hFF, 2'd3, 1, 1'b1,
			make_outcome(1'b1, 8'hFF, 2'd2, 1'b1, ST_OK)});
		plan.push_back('{OP_READY,   8'h00, 2'd0, 1, 1'b1,
			make_outcome(1'b1, 8'hFF, 2'd2, 1'b0, ST_OK)});
		plan.push_back('{OP_READY,   8'hAA, 2'd1, 1, 1'b0, none});
		plan.push_back('{OP_TIMEOUT, 8'h00, 2'd0, 1, 1'b0, none});
		plan.push_back('{OP_RELEASE, 8'h00, 2'd0, 1, 1'b0, none});
		plan.push_back('{OP_READY,   8'h55, 2'd2, 1, 1'b0, none});
		plan.push_back('{OP_RELEASE, 8'h00, 2'd0, 2, 1'b0, none});
		plan.push_back('{OP_RELEASE, 8'h00, 2'd0, 1, 1'b1, idle_res});
		// fill level 0: one runs, sixteen wait
		plan.push_back('{OP_READY,   8'h10, 2'd0, 17, 1'b0, none});
		plan.push_back('{OP_READY,   8'h01, 2'd0, 1, 1'b1,
			make_outcome(1'b1, 8'h10, 2'd0, 1'b0, ST_DROPPED)});
		// time-out into a full level loses the running process
		plan.push_back('{OP_TIMEOUT, 8'h00, 2'd0, 1, 1'b1,
			make_outcome(1'b1, 8'h11, 2'd0, 1'b1, ST_DROPPED)});
		plan.push_back('{OP_READY,   8'h02, 2'd0, 1, 1'b0, none});
		// preemption into a full level loses the preempted process
		plan.push_back('{OP_READY,   8'h80, 2'd1, 1, 1'b1,
			make_outcome(1'b1, 8'h80, 2'd1, 1'b1, ST_DROPPED)});
		plan.push_back('{OP_NOP,     8'hFF, 2'd3, 1, 1'b0, none});
		plan.push_back('{OP_RELEASE, 8'h00, 2'd0, 18, 1'b0, none});
		foreach (plan[i])
			for (int k = 0; k < plan[i].reps; k++)
				send_event(plan[i].op, PID_W'(plan[i].pid + k), plan[i].lvl,
					plan[i].typed, plan[i].want);

		// random events under three idling patterns
		for (int ph = 0; ph < 3; ph++) begin
			wait_results();
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 63 : 0;
			recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 12 : 0;
			ready_w = 45;
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				// change the fill pressure every fifty events
				if (n % 50 == 0)
					ready_w = $urandom_range(65, 25);
				r = $urandom_range(99);
				if (r < ready_w) begin
					op = OP_READY;
				end else begin
					r  = $urandom_range(99);
					op = (r < 45) ? OP_TIMEOUT : (r < 85) ? OP_RELEASE : OP_NOP;
				end
				send_event(op, PID_W'($urandom_range(255)), LVL_W'($urandom_range(3)),
					1'b0, none);
			end
		end

		// drain and let any stray result show
		wait_results();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d events under three idling patterns, %0d results checked",
			n_events, n_checked);
		$display("predicted %0d switches, %0d drops on full levels, %0d idle results",
			n_switch, n_drop, n_idle);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_priority_preemptive_scheduler_core OK");
		end else begin
			$display("tb_priority_preemptive_scheduler_core NOT OK");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_front.sv
hw/rtl/pps_fifo.sv
hw/rtl/pps_engine.sv
hw/rtl/priority_preemptive_scheduler_core.sv
test/tb_priority_preemptive_scheduler_core.sv
